@@ hw/rtl/indexed_list_store_defines.svh @@
// Assertion macros used by the list store RTL.
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked at every rising edge, masked while reset is high.
`define ILS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked at every rising edge, reset included.
`define ILS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ILS_ASSERT(lbl, prop, msg)
`define ILS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hw/rtl/ils_pkg.sv @@
// Types, widths and codes for the indexed list store.
package ils_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMD_W    = 3;
  localparam int IDX_W    = 7;
  localparam int DATA_W   = 32;
  localparam int ST_W     = 2;
  localparam int LEN_W    = 7;
  localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CMP_W-1:0]  cmp_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [ST_W-1:0]   status_t;
  typedef logic [CMD_W-1:0]  cmd_t;

  localparam cmd_t CMD_READ = 3'd0;
  localparam cmd_t CMD_HEAD = 3'd1;
  localparam cmd_t CMD_TAIL = 3'd2;
  localparam cmd_t CMD_AT   = 3'd3;
  localparam cmd_t CMD_DEL  = 3'd4;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  localparam data_t READ_MISS = '1;

endpackage

@@ hw/rtl/indexed_list_store.sv @@
// Indexed list store: ordered list of 32-bit values in a RAM with insert/delete by shifting.
// A read passes through S_RD to the hand-over state S_FIN; a rejected or unknown command goes
//   straight to S_FIN; an insert or delete first shifts entries through S_MV_RD and S_MV_WR.
// One command at a time: the next command is taken the cycle after the result registers, later
//   while it is held; each RAM move reads the source entry, then writes it to its new slot.
// Reset clears the length, sequencer and result valid; list RAM is not cleared.
`include "indexed_list_store_defines.svh"

module indexed_list_store (
  input  logic                clk,
  input  logic                rst,
  // command channel
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  logic [2:0]          command,
  input  logic [6:0]          index,
  input  logic signed [31:0]  value,
  // result channel
  output logic                res_valid,
  input  logic                res_stall,
  output logic signed [31:0]  read_value,
  output logic [1:0]          status,
  output logic [6:0]          length
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a command
  localparam logic [2:0] S_RD    = 3'd1;  // read data arrives from RAM
  localparam logic [2:0] S_MV_RD = 3'd2;  // test end of shift (on insert, place the new value), else fetch next source
  localparam logic [2:0] S_MV_WR = 3'd3;  // write fetched entry to its new slot
  localparam logic [2:0] S_FIN   = 3'd4;  // hand result to output register

  logic [2:0]       state, state_next;
  ils_pkg::cnt_t    count, count_next;
  ils_pkg::cnt_t    ptr, ptr_next;       // slot being filled during a shift
  ils_pkg::cnt_t    pos, pos_next;       // insert target
  logic             ins, ins_next;       // shift direction: 1 up (insert), 0 down
  ils_pkg::data_t   val, val_next;       // value to insert
  ils_pkg::data_t   res_val, res_val_next;
  ils_pkg::status_t res_st, res_st_next;

  // RAM port signals
  logic             ram_we;
  ils_pkg::addr_t   ram_waddr, ram_raddr;
  ils_pkg::data_t   ram_wdata, ram_rdata;

  logic             cmd_xfer, res_free, full;
  ils_pkg::cmp_t    idx_ext, cnt_ext;
  ils_pkg::cnt_t    ptr_inc, ptr_dec;

  assign cmd_stall = (state != S_IDLE);
  assign cmd_xfer  = cmd_valid && !cmd_stall;
  assign res_free  = !res_valid || !res_stall;
  assign full      = (count == ils_pkg::cnt_t'(ils_pkg::CAPACITY));
  assign idx_ext   = ils_pkg::cmp_t'(index);
  assign cnt_ext   = ils_pkg::cmp_t'(count);
  assign ptr_inc   = ptr + ils_pkg::cnt_t'(1);
  assign ptr_dec   = ptr - ils_pkg::cnt_t'(1);

  ils_ram #(
    .WIDTH (ils_pkg::DATA_W),
    .DEPTH (ils_pkg::CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next   = state;
    count_next   = count;
    ptr_next     = ptr;
    pos_next     = pos;
    ins_next     = ins;
    val_next     = val;
    res_val_next = res_val;
    res_st_next  = res_st;
    ram_we       = 1'b0;
    ram_waddr    = ils_pkg::addr_t'(ptr);
    ram_wdata    = ram_rdata;
    ram_raddr    = ils_pkg::addr_t'(index);

    case (state)
      S_IDLE: begin
        if (cmd_xfer) begin
          res_val_next = '0;
          res_st_next  = ils_pkg::ST_DONE;
          val_next     = ils_pkg::data_t'(value);
          state_next   = S_FIN;
          case (command)
            ils_pkg::CMD_READ: begin
              // RAM read address is the index itself this cycle
              if (idx_ext < cnt_ext) begin
                state_next = S_RD;
              end else begin
                res_val_next = ils_pkg::READ_MISS;
                res_st_next  = ils_pkg::ST_RANGE;
              end
            end
            ils_pkg::CMD_HEAD, ils_pkg::CMD_TAIL: begin
              if (full) begin
                res_st_next = ils_pkg::ST_FULL;
              end else begin
                ins_next   = 1'b1;
                ptr_next   = count;
                pos_next   = (command == ils_pkg::CMD_HEAD) ? '0 : count;
                state_next = S_MV_RD;
              end
            end
            ils_pkg::CMD_AT: begin
              // range check takes precedence over full
              if (idx_ext > cnt_ext) begin
                res_st_next = ils_pkg::ST_RANGE;
              end else if (full) begin
                res_st_next = ils_pkg::ST_FULL;
              end else begin
                ins_next   = 1'b1;
                ptr_next   = count;
                pos_next   = ils_pkg::cnt_t'(index);
                state_next = S_MV_RD;
              end
            end
            ils_pkg::CMD_DEL: begin
              if (idx_ext >= cnt_ext) begin
                res_st_next = ils_pkg::ST_RANGE;
              end else begin
                ins_next   = 1'b0;
                ptr_next   = ils_pkg::cnt_t'(index);
                state_next = S_MV_RD;
              end
            end
            default: begin
              // unknown command: no change, done status
            end
          endcase
        end
      end

      S_RD: begin
        res_val_next = ram_rdata;
        state_next   = S_FIN;
      end

      S_MV_RD: begin
        if (ins) begin
          if (ptr == pos) begin
            // gap has reached the target slot: drop the new value in
            ram_we     = 1'b1;
            ram_waddr  = ils_pkg::addr_t'(pos);
            ram_wdata  = val;
            count_next = count + ils_pkg::cnt_t'(1);
            state_next = S_FIN;
          end else begin
            ram_raddr  = ils_pkg::addr_t'(ptr_dec);
            state_next = S_MV_WR;
          end
        end else begin
          if (ptr_inc >= count) begin
            count_next = count - ils_pkg::cnt_t'(1);
            state_next = S_FIN;
          end else begin
            ram_raddr  = ils_pkg::addr_t'(ptr_inc);
            state_next = S_MV_WR;
          end
        end
      end

      S_MV_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = ils_pkg::addr_t'(ptr);
        ram_wdata  = ram_rdata;
        ptr_next   = ins ? ptr_dec : ptr_inc;
        state_next = S_MV_RD;
      end

      S_FIN: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if ((state == S_FIN) && res_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    pos     <= pos_next;
    ins     <= ins_next;
    val     <= val_next;
    res_val <= res_val_next;
    res_st  <= res_st_next;
    if ((state == S_FIN) && res_free) begin
      read_value <= res_val;
      status     <= res_st;
      length     <= ils_pkg::LEN_W'(count);
    end
  end

  // Length never exceeds the store size
  `ILS_ASSERT_ALWAYS(a_count_bound, rst || (count <= ils_pkg::cnt_t'(ils_pkg::CAPACITY)), "list length above capacity")

  // Length moves by at most one per cycle outside reset
  `ILS_ASSERT(a_count_step, (!$past(rst) && (count != $past(count))) |-> ((count == $past(count) + 1) || (count + 1 == $past(count))), "list length jumped")

  // A new result only ever appears from the hand-over state
  `ILS_ASSERT(a_res_from_fin, $rose(res_valid) |-> ($past(state) == S_FIN), "result raised outside hand-over")

  // RAM is written only while shifting or placing a value
  `ILS_ASSERT(a_we_in_shift, ram_we |-> ((state == S_MV_RD) || (state == S_MV_WR)), "RAM write outside shift")

endmodule

@@ hw/rtl/ils_ram.sv @@
// Generic one-write, one-read RAM with registered read data.
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
